[hw/rtl/lbw_pkg.sv]
// Shared types and constants for the link backoff and low-memory watchdog.
// Holds the transaction payload structs, the register index codes and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lbw_pkg;

  // reset values of the configuration registers
  localparam logic [23:0] MEM_LOW_LEVEL_RST  = 24'd15000;
  localparam logic [31:0] MEM_LOW_WINDOW_RST = 32'd2000;
  localparam logic [31:0] PEER_DEFER_RST     = 32'd60000;
  localparam logic [19:0] BACKOFF_INIT_RST   = 20'd5000;
  localparam logic [19:0] BACKOFF_CAP_RST    = 20'd60000;

  // default width of stored timestamps
  localparam int unsigned TIME_BITS_DEF = 32;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_MEM_LOW_LEVEL  = 3'd0,
    REG_MEM_LOW_WINDOW = 3'd1,
    REG_PEER_DEFER     = 3'd2,
    REG_BACKOFF_INIT   = 3'd3,
    REG_BACKOFF_CAP    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        link_up;
    logic [23:0] free_memory;
    logic        peer_connected;
    logic        setup_done;
    logic        credentials_present;
  } in_item_t;

  typedef struct packed {
    logic        restart_request;
    logic        restart_deferred;
    logic        reconnect_request;
    logic [19:0] next_gap_ms;
    logic [31:0] reconnect_total;
  } out_item_t;

  // current configuration handed to the tick logic
  typedef struct packed {
    logic [23:0] memory_low_level;
    logic [31:0] memory_low_window_ms;
    logic [31:0] peer_defer_limit_ms;
    logic [19:0] backoff_initial_ms;
    logic [19:0] backoff_cap_ms;
  } cfg_regs_t;

endpackage

`default_nettype wire

[hw/rtl/lbw_core.sv]
// Per-tick supervision logic: low-memory watchdog and reconnect backoff state.
// Computes one result per tick and updates its state on the step strobe.
// Depends on lbw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbw_core import lbw_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire in_item_t  item_i,
  input  wire cfg_regs_t cfg_i,
  output out_item_t      result_o
);

  // compare width covers both timestamps and 32-bit limits
  localparam int unsigned CW = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic                 mem_low_active_q, mem_low_active_d;
  logic [TIME_BITS-1:0] mem_low_start_q, mem_low_start_d;
  logic                 link_down_q, link_down_d;
  logic [TIME_BITS-1:0] last_attempt_q, last_attempt_d;
  logic [19:0]          gap_q, gap_d;
  logic [31:0]          count_q, count_d;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] mem_elapsed;
  logic [TIME_BITS-1:0] link_elapsed;
  logic [TIME_BITS-1:0] last_eff;
  logic [19:0]          gap_eff;
  logic [20:0]          doubled;
  logic                 restart, deferred, reconnect;
  logic                 mem_critical, backoff_armed;

  // timestamp taken modulo the stored width
  assign now_t = TIME_BITS'(CW'(item_i.now_ms));

  // low-memory watchdog
  assign mem_critical = item_i.free_memory < cfg_i.memory_low_level;
  assign mem_elapsed  = now_t - mem_low_start_q;

  always_comb begin
    mem_low_active_d = mem_low_active_q;
    mem_low_start_d  = mem_low_start_q;
    restart          = 1'b0;
    deferred         = 1'b0;
    if (mem_critical) begin
      if (!mem_low_active_q) begin
        mem_low_active_d = 1'b1;
        mem_low_start_d  = now_t;
      end else if (CW'(mem_elapsed) >= CW'(cfg_i.memory_low_window_ms)) begin
        if (item_i.peer_connected &&
            (CW'(mem_elapsed) < CW'(cfg_i.peer_defer_limit_ms))) begin
          deferred = 1'b1;
        end else begin
          restart = 1'b1;
        end
      end
    end else begin
      mem_low_active_d = 1'b0;
    end
  end

  // reconnect backoff
  assign backoff_armed = item_i.setup_done && item_i.credentials_present && !item_i.link_up;
  assign gap_eff  = link_down_q ? gap_q : cfg_i.backoff_initial_ms;
  assign last_eff = link_down_q ? last_attempt_q : (now_t - TIME_BITS'(CW'(gap_eff)));
  assign link_elapsed = now_t - last_eff;
  assign doubled  = {gap_eff, 1'b0};

  always_comb begin
    link_down_d    = link_down_q;
    last_attempt_d = last_attempt_q;
    gap_d          = gap_q;
    count_d        = count_q;
    reconnect      = 1'b0;
    if (backoff_armed) begin
      link_down_d    = 1'b1;
      gap_d          = gap_eff;
      last_attempt_d = last_eff;
      if (CW'(link_elapsed) >= CW'(gap_eff)) begin
        reconnect      = 1'b1;
        count_d        = count_q + 32'd1;
        last_attempt_d = now_t;
        gap_d          = (doubled < {1'b0, cfg_i.backoff_cap_ms}) ? doubled[19:0]
                                                                  : cfg_i.backoff_cap_ms;
      end
    end else if (item_i.link_up) begin
      link_down_d = 1'b0;
      gap_d       = 20'd0;
    end
  end

  // state registers, advance once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_low_active_q <= 1'b0;
      mem_low_start_q  <= '0;
      link_down_q      <= 1'b0;
      last_attempt_q   <= '0;
      gap_q            <= '0;
      count_q          <= '0;
    end else if (step_i) begin
      mem_low_active_q <= mem_low_active_d;
      mem_low_start_q  <= mem_low_start_d;
      link_down_q      <= link_down_d;
      last_attempt_q   <= last_attempt_d;
      gap_q            <= gap_d;
      count_q          <= count_d;
    end
  end

  always_comb begin
    result_o.restart_request   = restart;
    result_o.restart_deferred  = deferred;
    result_o.reconnect_request = reconnect;
    result_o.next_gap_ms       = gap_d;
    result_o.reconnect_total   = count_d;
  end

  // count moves by one exactly on a reconnect tick
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |=> (count_q == $past(count_q) + 32'($past(reconnect))))
    else $error("reconnect count out of step with requests");

  // no tick, no state change
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(count_q) && $stable(gap_q) && $stable(mem_low_active_q)))
    else $error("state changed without a tick");

  // gap is zero whenever the backoff is not in its link-down state
  a_gap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !link_down_q |-> (gap_q == 20'd0))
    else $error("nonzero gap while link not down");

endmodule

`default_nettype wire

[hw/rtl/link_backoff_and_low_memory_watchdog_top.sv]
// Top level of the link backoff and low-memory watchdog.
// Holds the configuration registers and the output staging; instantiates lbw_core.
// Depends on lbw_pkg and lbw_core.
`timescale 1ns / 1ps
`default_nettype none

// One supervision tick is taken per cycle when in_ready_o is high and yields
// exactly one result transaction, so sustained throughput is one tick per
// clock while the consumer takes results. The tick logic (three timestamp
// subtractions, compares and one doubling) sits between the input port and a
// result register; a second skid register behind it lets the block take one
// more tick while the consumer stalls. Configuration writes are always ready
// and should be issued only while no tick is in flight. Stored timestamps are
// TIME_BITS wide and all time differences wrap modulo 2^TIME_BITS.
module link_backoff_and_low_memory_watchdog_top import lbw_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_item_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  cfg_regs_t cfg_q;
  out_item_t result;
  out_item_t out_q, skid_q;
  logic      out_valid_q, skid_valid_q;
  logic      accept, pop;

  // configuration register writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.memory_low_level     <= MEM_LOW_LEVEL_RST;
      cfg_q.memory_low_window_ms <= MEM_LOW_WINDOW_RST;
      cfg_q.peer_defer_limit_ms  <= PEER_DEFER_RST;
      cfg_q.backoff_initial_ms   <= BACKOFF_INIT_RST;
      cfg_q.backoff_cap_ms       <= BACKOFF_CAP_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_MEM_LOW_LEVEL:  cfg_q.memory_low_level     <= cfg_data_i[23:0];
        REG_MEM_LOW_WINDOW: cfg_q.memory_low_window_ms <= cfg_data_i;
        REG_PEER_DEFER:     cfg_q.peer_defer_limit_ms  <= cfg_data_i;
        REG_BACKOFF_INIT:   cfg_q.backoff_initial_ms   <= cfg_data_i[19:0];
        REG_BACKOFF_CAP:    cfg_q.backoff_cap_ms       <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  // tick handshake
  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign pop        = out_valid_q && out_ready_i;

  lbw_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .item_i   (in_item_i),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  // result register and skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= accept;
        end
      end else if (!out_valid_q) begin
        out_valid_q <= accept;
      end else if (accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end else if (accept && (pop || !out_valid_q)) begin
      out_q <= result;
    end
    if (accept && out_valid_q && !pop) begin
      skid_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // skid entry only exists behind a full result register
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without result entry");

  // a tick into a stalled full result register lands in the skid stage
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && out_valid_q && !out_ready_i) |=> skid_valid_q)
    else $error("tick lost while output stalled");

  // draining the skid stage keeps a result on the output
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && skid_valid_q) |=> (out_valid_q && !skid_valid_q))
    else $error("skid drain dropped a result");

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for the link backoff and low-memory watchdog top level.
// Predicts every result transaction from its own model of the watchdog and backoff timer.
// Depends on lbw_pkg and link_backoff_and_low_memory_watchdog_top.
`timescale 1ns / 1ps

module testbench;
  import lbw_pkg::*;

  // index with no register behind it, writes there must be ignored
  localparam logic [2:0] REG_SPARE = 3'd7;

  // tracks watchdog and backoff state, holds expected results in order
  class tick_tracker;
    cfg_regs_t   regs;
    bit          mem_low_active;
    logic [31:0] mem_low_start;
    bit          link_down_active;
    logic [31:0] last_attempt;
    logic [19:0] gap;
    logic [31:0] reconnects;
    out_item_t   expected_results[$];
    int unsigned failures;

    function new();
      regs.memory_low_level     = MEM_LOW_LEVEL_RST;
      regs.memory_low_window_ms = MEM_LOW_WINDOW_RST;
      regs.peer_defer_limit_ms  = PEER_DEFER_RST;
      regs.backoff_initial_ms   = BACKOFF_INIT_RST;
      regs.backoff_cap_ms       = BACKOFF_CAP_RST;
      mem_low_active   = 1'b0;
      mem_low_start    = '0;
      link_down_active = 1'b0;
      last_attempt     = '0;
      gap              = '0;
      reconnects       = '0;
      failures         = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_MEM_LOW_LEVEL:  regs.memory_low_level     = data[23:0];
        REG_MEM_LOW_WINDOW: regs.memory_low_window_ms = data;
        REG_PEER_DEFER:     regs.peer_defer_limit_ms  = data;
        REG_BACKOFF_INIT:   regs.backoff_initial_ms   = data[19:0];
        REG_BACKOFF_CAP:    regs.backoff_cap_ms       = data[19:0];
        default: ;
      endcase
    endfunction

    // one accepted tick: update state and queue the expected result
    function void note_tick(in_item_t t);
      out_item_t   want;
      logic [31:0] elapsed;
      logic [20:0] doubled;
      want = '0;

      // low-memory watchdog
      if (t.free_memory < regs.memory_low_level) begin
        if (!mem_low_active) begin
          mem_low_active = 1'b1;
          mem_low_start  = t.now_ms;
        end else begin
          elapsed = t.now_ms - mem_low_start;
          if (elapsed >= regs.memory_low_window_ms) begin
            if (t.peer_connected && elapsed < regs.peer_defer_limit_ms)
              want.restart_deferred = 1'b1;
            else
              want.restart_request = 1'b1;
          end
        end
      end else begin
        mem_low_active = 1'b0;
      end

      // reconnect backoff
      if (t.setup_done && t.credentials_present && !t.link_up) begin
        if (!link_down_active) begin
          link_down_active = 1'b1;
          gap              = regs.backoff_initial_ms;
          last_attempt     = t.now_ms - {12'd0, gap};
        end
        if (t.now_ms - last_attempt >= {12'd0, gap}) begin
          doubled = {gap, 1'b0};
          reconnects   = reconnects + 1;
          last_attempt = t.now_ms;
          want.reconnect_request = 1'b1;
          gap = (doubled < {1'b0, regs.backoff_cap_ms}) ? doubled[19:0] : regs.backoff_cap_ms;
        end
      end else if (t.link_up) begin
        link_down_active = 1'b0;
        gap              = '0;
      end

      want.next_gap_ms     = gap;
      want.reconnect_total = reconnects;
      expected_results.push_back(want);
    endfunction

    function void report_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        failures++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        failures++;
        $display("%0t ns: result with nothing expected, expected none, actual %p", $time, got);
        return;
      end
      want = expected_results.pop_front();
      report_field("restart_request", 64'(want.restart_request), 64'(got.restart_request));
      report_field("restart_deferred", 64'(want.restart_deferred),
                   64'(got.restart_deferred));
      report_field("reconnect_request", 64'(want.reconnect_request),
                   64'(got.reconnect_request));
      report_field("next_gap_ms", 64'(want.next_gap_ms), 64'(got.next_gap_ms));
      report_field("reconnect_total", 64'(want.reconnect_total), 64'(got.reconnect_total));
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  bit in_burst  = 1'b0;
  bit out_burst = 1'b0;

  tick_tracker tracker = new();

  link_backoff_and_low_memory_watchdog_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // hard stop if the run hangs
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // transaction monitor, samples the values seen at the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) tracker.check_result(out_item_o);
      if (in_valid_i && in_ready_o) tracker.note_tick(in_item_i);
    end
  end

  function automatic int unsigned draw_wait(bit burst);
    return burst ? 0 : $urandom_range(0, 7);
  endfunction

  // result side: random stall before each transaction
  initial begin
    int unsigned n;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      n = draw_wait(out_burst);
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  task automatic send_tick(input in_item_t t);
    int unsigned n;
    n = draw_wait(in_burst);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= t;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  task automatic tick(input logic [31:0] now, input bit up, input logic [23:0] mem,
                      input bit peer, input bit ready, input bit creds);
    in_item_t t;
    t.now_ms              = now;
    t.link_up             = up;
    t.free_memory         = mem;
    t.peer_connected      = peer;
    t.setup_done          = ready;
    t.credentials_present = creds;
    send_tick(t);
  endtask

  // wait until every expected result has come back
  task automatic wait_drained();
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  // write all registers back to back, unused upper data bits random, plus the spare index
  task automatic load_settings(input cfg_regs_t s);
    logic [2:0]  idx [6];
    logic [31:0] val [6];
    idx[0] = REG_MEM_LOW_LEVEL;
    val[0] = ($urandom & 32'hFF00_0000) | {8'd0, s.memory_low_level};
    idx[1] = REG_MEM_LOW_WINDOW;
    val[1] = s.memory_low_window_ms;
    idx[2] = REG_PEER_DEFER;
    val[2] = s.peer_defer_limit_ms;
    idx[3] = REG_BACKOFF_INIT;
    val[3] = ($urandom & 32'hFFF0_0000) | {12'd0, s.backoff_initial_ms};
    idx[4] = REG_BACKOFF_CAP;
    val[4] = ($urandom & 32'hFFF0_0000) | {12'd0, s.backoff_cap_ms};
    idx[5] = REG_SPARE;
    val[5] = $urandom;
    for (int i = 0; i < 6; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
      tracker.write_reg(cfg_index_i, cfg_data_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    cfg_regs_t   s;
    in_item_t    t;
    logic [31:0] now;
    int unsigned step_max;
    bit          up;
    bit          low;
    bit          peer;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: watchdog window, deferral, backoff doubling up to the cap
    tick(32'd1000, 1, 24'd0, 0, 1, 1);
    tick(32'd1000, 1, 24'd0, 0, 1, 1);
    tick(32'd3000, 1, 24'd14999, 0, 1, 1);
    tick(32'd3500, 1, 24'd0, 1, 1, 1);
    tick(32'd61000, 1, 24'd0, 1, 1, 1);
    tick(32'd62000, 1, 24'd15000, 0, 1, 1);
    tick(32'd63000, 0, 24'hFFFFFF, 0, 1, 1);
    tick(32'd66000, 0, 24'hFFFFFF, 0, 1, 1);
    tick(32'd73000, 0, 24'hFFFFFF, 0, 1, 1);
    // link down but setup or credentials missing: backoff holds
    tick(32'd100000, 0, 24'hFFFFFF, 0, 0, 1);
    tick(32'd100000, 0, 24'hFFFFFF, 0, 1, 0);
    tick(32'd93000, 0, 24'hFFFFFF, 0, 1, 1);
    tick(32'd133000, 0, 24'hFFFFFF, 0, 1, 1);
    tick(32'd193000, 0, 24'hFFFFFF, 0, 1, 1);
    tick(32'd200000, 1, 24'hFFFFFF, 0, 1, 1);
    // timestamps wrapping around
    tick(32'hFFFF_FF00, 1, 24'd100, 0, 1, 1);
    tick(32'h0000_0800, 1, 24'd100, 1, 1, 1);
    tick(32'h0000_0900, 0, 24'd100, 0, 1, 1);
    tick(32'hFFFF_FFFF, 1, 24'hFFFFFF, 1, 1, 1);
    in_valid_i <= 1'b0;
    wait_drained();

    // zero window, zero deferral, initial gap above the cap
    s.memory_low_level     = MEM_LOW_LEVEL_RST;
    s.memory_low_window_ms = 32'd0;
    s.peer_defer_limit_ms  = 32'd0;
    s.backoff_initial_ms   = 20'd1000;
    s.backoff_cap_ms       = 20'd300;
    load_settings(s);
    tick(32'd5000, 1, 24'd0, 1, 1, 1);
    tick(32'd5000, 1, 24'd0, 1, 1, 1);
    tick(32'd5000, 0, 24'hFFFFFF, 0, 1, 1);
    tick(32'd5300, 0, 24'hFFFFFF, 0, 1, 1);
    in_valid_i <= 1'b0;
    wait_drained();

    // zero initial gap: a request on every link-down tick
    s.backoff_initial_ms = 20'd0;
    s.backoff_cap_ms     = 20'hFFFFF;
    load_settings(s);
    tick(32'd6000, 1, 24'hFFFFFF, 0, 1, 1);
    tick(32'd6000, 0, 24'hFFFFFF, 0, 1, 1);
    tick(32'd6000, 0, 24'hFFFFFF, 0, 1, 1);
    in_valid_i <= 1'b0;
    wait_drained();

    // random phases, each under its own register setting
    now  = $urandom;
    up   = 1'b1;
    low  = 1'b0;
    peer = 1'b0;
    for (int p = 0; p < 10; p++) begin
      case (p % 5)
        0: begin
          s.memory_low_level     = MEM_LOW_LEVEL_RST;
          s.memory_low_window_ms = MEM_LOW_WINDOW_RST;
          s.peer_defer_limit_ms  = PEER_DEFER_RST;
          s.backoff_initial_ms   = BACKOFF_INIT_RST;
          s.backoff_cap_ms       = BACKOFF_CAP_RST;
          step_max = 9000;
        end
        1: begin
          s.memory_low_level     = 24'd4096;
          s.memory_low_window_ms = 32'd40;
          s.peer_defer_limit_ms  = 32'd150;
          s.backoff_initial_ms   = 20'd8;
          s.backoff_cap_ms       = 20'd100;
          step_max = 30;
        end
        2: begin
          // widest settings, time driven across the wrap
          s.memory_low_level     = 24'hFFFFFF;
          s.memory_low_window_ms = 32'd0;
          s.peer_defer_limit_ms  = 32'hFFFF_FFFF;
          s.backoff_initial_ms   = 20'hFFFFF;
          s.backoff_cap_ms       = 20'hFFFFF;
          step_max = 32'h0020_0000;
          now = 32'hFFE0_0000;
        end
        3: begin
          s.memory_low_level     = (p < 5) ? 24'd1 : 24'd0;
          s.memory_low_window_ms = 32'hFFFF_FFFF;
          s.peer_defer_limit_ms  = 32'd0;
          s.backoff_initial_ms   = 20'd0;
          s.backoff_cap_ms       = 20'd0;
          step_max = 100;
        end
        default: begin
          s.memory_low_level     = 24'($urandom);
          s.memory_low_window_ms = $urandom_range(0, 500);
          s.peer_defer_limit_ms  = $urandom_range(0, 2000);
          s.backoff_initial_ms   = 20'($urandom_range(1, 200));
          s.backoff_cap_ms       = 20'($urandom_range(1, 400));
          step_max = 300;
        end
      endcase
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      load_settings(s);

      for (int k = 0; k < 65; k++) begin
        if ($urandom_range(0, 15) == 0) begin
          // noise: every field random
          t.now_ms              = $urandom;
          t.link_up             = 1'($urandom);
          t.free_memory         = 24'($urandom);
          t.peer_connected      = 1'($urandom);
          t.setup_done          = 1'($urandom);
          t.credentials_present = 1'($urandom);
          now = t.now_ms;
        end else begin
          // episodes of link loss, low memory and peer presence
          if ($urandom_range(0, 11) == 0) up = !up;
          if ($urandom_range(0, 9) == 0) low = !low;
          if ($urandom_range(0, 7) == 0) peer = !peer;
          now = now + $urandom_range(0, step_max);
          t.now_ms         = now;
          t.link_up        = up;
          t.peer_connected = peer;
          if (low)
            t.free_memory = 24'((s.memory_low_level == 0) ? $urandom
                                : $urandom_range(0, s.memory_low_level - 1));
          else
            t.free_memory = 24'($urandom_range(s.memory_low_level, 24'hFFFFFF));
          t.setup_done          = ($urandom_range(0, 9) != 0);
          t.credentials_present = ($urandom_range(0, 9) != 0);
        end
        send_tick(t);
      end
      in_valid_i <= 1'b0;
      wait_drained();
    end

    // let any stray result surface before the verdict
    repeat (4) @(posedge clk_i);
    if (tracker.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/lbw_pkg.sv
hw/rtl/lbw_core.sv
hw/rtl/link_backoff_and_low_memory_watchdog_top.sv
bench/testbench.sv
